FILE: rtl/buddy_block_allocator_top_defines.svh
// Assertion macros for the buddy allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// consequent checked on the following edge
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked on the same edge
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

  localparam int ADDR_BITS = 10;
  localparam int LEVELS    = 8;
  localparam int NODES     = (1 << (LEVELS + 1)) - 1;
  localparam int IDX_W     = $clog2(NODES);
  localparam int DEPTH_W   = $clog2(LEVELS + 1);
  localparam int ORD_W     = 4;
  localparam int SIZE_W    = ADDR_BITS + 1;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 3;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_OCC   = 2'd1;
  localparam logic [1:0] ST_SPLIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER = CFG_IDX_W'(1);

  typedef enum logic [STAT_W-1:0] {
    RES_ALLOCATED = 3'd0,
    RES_NO_SPACE  = 3'd1,
    RES_TOO_BIG   = 3'd2,
    RES_RELEASED  = 3'd3,
    RES_NOT_FOUND = 3'd4
  } res_t;

  typedef enum logic [2:0] {
    MV_HOLD  = 3'd0,
    MV_LEFT  = 3'd1,
    MV_CHILD = 3'd2,
    MV_SIB   = 3'd3,
    MV_UP    = 3'd4
  } mv_t;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       rd_en;
    logic       rd_sib;
    logic       wr_en;
    logic       wr_parent;
    logic [1:0] wr_val;
    mv_t        mv;
    logic       res_init;
    logic       res_hit;
    logic       cf_capture;
    logic       out_load;
  } bba_cmd_t;

  typedef struct packed {
    logic       cfg_wr;
    logic       is_alloc;
    logic       too_big;
    logic       out_pool;
    logic [1:0] node_st;
    logic       fits;
    logic       at_limit;
    logic       hit;
    logic       is_root;
    logic       is_left;
    logic       cur_free;
    logic       clr_last;
  } bba_stat_t;

endpackage

FILE: rtl/bba_dp.sv
`timescale 1ns / 1ps
module bba_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           kind,
  input  logic [bba_pkg::SIZE_W-1:0]     request_size,
  input  logic [bba_pkg::ADDR_BITS-1:0]  release_address,
  input  bba_pkg::bba_cmd_t              cmd,
  output bba_pkg::bba_stat_t             stat,
  output logic [bba_pkg::STAT_W-1:0]     status,
  output logic [bba_pkg::ADDR_BITS-1:0]  block_address,
  output logic [bba_pkg::ORD_W-1:0]      block_order
);
  import bba_pkg::*;

  logic [CFG_W-1:0]     min_order;
  logic [CFG_W-1:0]     max_order;
  logic                 is_alloc;
  logic [SIZE_W-1:0]    need;
  logic [ADDR_BITS-1:0] addr;
  logic [ORD_W-1:0]     top_order;
  logic [DEPTH_W-1:0]   depth_lim;
  logic [IDX_W-1:0]     idx;
  logic [DEPTH_W-1:0]   depth;
  logic [ADDR_BITS-1:0] start;
  logic                 cur_free;
  logic [IDX_W-1:0]     clr_cnt;
  logic [1:0]           rdata;
  res_t                 res_st;
  logic [ADDR_BITS-1:0] res_addr;
  logic [ORD_W-1:0]     res_order;
  logic [1:0]           mem [NODES];

  logic                 cfg_wr;
  logic [ORD_W-1:0]     m_eff;
  logic [ORD_W-1:0]     lo_eff;
  logic [ORD_W-1:0]     span;
  logic [DEPTH_W-1:0]   dl_eff;
  logic [ORD_W-1:0]     order;
  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-1:0]    half;
  logic [SIZE_W-1:0]    mid;
  logic [SIZE_W-1:0]    pool;
  logic                 go_right;
  logic                 hit;
  logic [IDX_W-1:0]     parent;
  logic [IDX_W-1:0]     sibling;
  logic [IDX_W-1:0]     child;
  logic [IDX_W-1:0]     wa;
  logic [IDX_W-1:0]     ra;
  logic [1:0]           wd;
  logic                 we;

  assign cfg_wr = cfg_we && (cfg_index == REG_MIN_ORDER || cfg_index == REG_MAX_ORDER);

  always_comb begin
    m_eff  = (max_order > CFG_W'(ADDR_BITS)) ? ORD_W'(ADDR_BITS) : max_order;
    lo_eff = (min_order > m_eff) ? m_eff : min_order;
    span   = m_eff - lo_eff;
    dl_eff = (span > ORD_W'(LEVELS)) ? DEPTH_W'(LEVELS) : DEPTH_W'(span);
  end

  assign order    = top_order - ORD_W'(depth);
  assign size     = SIZE_W'(1) << order;
  assign half     = size >> 1;
  assign mid      = {1'b0, start} + half;
  assign pool     = SIZE_W'(1) << top_order;
  assign go_right = {1'b0, addr} >= mid;
  assign hit      = addr == start;
  assign parent   = (idx - IDX_W'(1)) >> 1;
  assign sibling  = idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  assign child    = (idx << 1) + IDX_W'(1);

  assign wa = cmd.clr ? clr_cnt : (cmd.wr_parent ? parent : idx);
  assign wd = cmd.clr ? ST_FREE : cmd.wr_val;
  assign we = cmd.clr || cmd.wr_en;
  assign ra = cmd.rd_sib ? sibling : idx;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_order <= CFG_W'(3);
      max_order <= CFG_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_ORDER: min_order <= cfg_data;
        REG_MAX_ORDER: max_order <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_alloc  <= !kind;
      need      <= request_size;
      addr      <= release_address;
      top_order <= m_eff;
      depth_lim <= dl_eff;
      idx       <= '0;
      depth     <= '0;
      start     <= '0;
    end else begin
      case (cmd.mv)
        MV_LEFT: begin
          idx   <= child;
          depth <= depth + DEPTH_W'(1);
        end
        MV_CHILD: begin
          idx   <= child + IDX_W'(go_right);
          depth <= depth + DEPTH_W'(1);
          if (go_right) begin
            start <= ADDR_BITS'(mid);
          end
        end
        MV_SIB: begin
          idx   <= idx + IDX_W'(1);
          start <= ADDR_BITS'({1'b0, start} + size);
        end
        MV_UP: begin
          idx   <= parent;
          depth <= depth - DEPTH_W'(1);
          if (!idx[0]) begin
            start <= ADDR_BITS'({1'b0, start} - size);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cf_capture) begin
      cur_free <= (rdata == ST_OCC) ? hit : (rdata == ST_FREE);
    end
    if (cmd.res_init) begin
      res_st    <= is_alloc ? ((need > pool) ? RES_TOO_BIG : RES_NO_SPACE) : RES_NOT_FOUND;
      res_addr  <= '0;
      res_order <= '0;
    end else if (cmd.res_hit) begin
      res_st    <= is_alloc ? RES_ALLOCATED : RES_RELEASED;
      res_addr  <= start;
      res_order <= order;
    end
    if (cmd.out_load) begin
      status        <= res_st;
      block_address <= res_addr;
      block_order   <= res_order;
    end
  end

  always_comb begin
    stat.cfg_wr   = cfg_wr;
    stat.is_alloc = is_alloc;
    stat.too_big  = need > pool;
    stat.out_pool = {1'b0, addr} >= pool;
    stat.node_st  = rdata;
    stat.fits     = (depth < depth_lim) && (need <= half);
    stat.at_limit = depth >= depth_lim;
    stat.hit      = hit;
    stat.is_root  = idx == '0;
    stat.is_left  = idx[0];
    stat.cur_free = cur_free;
    stat.clr_last = clr_cnt == IDX_W'(NODES - 1);
  end

endmodule

FILE: rtl/bba_ctrl.sv
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_defines.svh"
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_READ   = 9'b000001000,
    S_EVAL   = 9'b000010000,
    S_BACK   = 9'b000100000,
    S_UNWIND = 9'b001000000,
    S_UEVAL  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.res_init = 1'b1;
        if (stat.is_alloc ? stat.too_big : stat.out_pool) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_alloc) begin
          if (stat.node_st == ST_FREE && stat.fits) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_val = ST_SPLIT;
            cmd.mv     = MV_LEFT;
            state_next = S_READ;
          end else if (stat.node_st == ST_FREE) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_val  = ST_OCC;
            cmd.res_hit = 1'b1;
            state_next  = S_DONE;
          end else if (stat.node_st == ST_SPLIT && stat.fits) begin
            cmd.mv     = MV_LEFT;
            state_next = S_READ;
          end else begin
            state_next = S_BACK;
          end
        end else begin
          if (stat.node_st == ST_SPLIT && !stat.at_limit) begin
            cmd.mv     = MV_CHILD;
            state_next = S_READ;
          end else begin
            cmd.cf_capture = 1'b1;
            if (stat.node_st == ST_OCC && stat.hit) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_val  = ST_FREE;
              cmd.res_hit = 1'b1;
            end
            state_next = S_UNWIND;
          end
        end
      end
      S_BACK: begin
        if (stat.is_root) begin
          state_next = S_DONE;
        end else if (stat.is_left) begin
          cmd.mv     = MV_SIB;
          state_next = S_READ;
        end else begin
          cmd.mv = MV_UP;
        end
      end
      S_UNWIND: begin
        if (stat.is_root || !stat.cur_free) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sib = 1'b1;
          state_next = S_UEVAL;
        end
      end
      S_UEVAL: begin
        if (stat.node_st == ST_FREE) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_parent = 1'b1;
          cmd.wr_val    = ST_FREE;
          cmd.mv        = MV_UP;
          state_next    = S_UNWIND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!(rsp_valid && rsp_stall)) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (stat.cfg_wr) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `BBA_ASSERT_NEXT(a_done_presents, state == S_DONE && !(rsp_valid && rsp_stall) && !stat.cfg_wr, rsp_valid && state == S_IDLE, "result beat not presented")
  `BBA_ASSERT_NEXT(a_root_fail_ends, state == S_BACK && stat.is_root && !stat.cfg_wr, state == S_DONE, "search past root")
  `BBA_ASSERT_NEXT(a_split_descends, state == S_EVAL && stat.is_alloc && stat.node_st == ST_FREE && stat.fits && !stat.cfg_wr, state == S_READ, "split without descent")
  `BBA_ASSERT_NOW(a_write_in_walk, cmd.wr_en, state == S_EVAL || state == S_UEVAL, "tree written outside walk")

endmodule

FILE: rtl/buddy_block_allocator_top.sv
// Buddy allocator, one request at a time over a 511-node state tree in a memory.
// Each node visited passes through a read state and an evaluate state; a backtrack step up is
// taken within the backtrack state. The result sits in an output register, so a new request is
// taken while it waits. After reset and after each write to the min-order or max-order register
// a clearing pass frees every node.
`timescale 1ns / 1ps
module buddy_block_allocator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                kind,
  input  logic [bba_pkg::SIZE_W-1:0]          request_size,
  input  logic [bba_pkg::ADDR_BITS-1:0]       release_address,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [bba_pkg::STAT_W-1:0]          status,
  output logic [bba_pkg::ADDR_BITS-1:0]       block_address,
  output logic [bba_pkg::ORD_W-1:0]           block_order
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .request_size    (request_size),
    .release_address (release_address),
    .cmd             (cmd),
    .stat            (stat),
    .status          (status),
    .block_address   (block_address),
    .block_order     (block_order)
  );

endmodule

FILE: tb/tb_buddy_block_allocator_top.sv
`timescale 1ns / 1ps
module tb_buddy_block_allocator_top;
  import bba_pkg::*;

  typedef struct {
    logic                 kind;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] addr;
  } alloc_req_t;

  typedef struct {
    res_t                 st;
    logic [ADDR_BITS-1:0] addr;
    logic [ORD_W-1:0]     ord;
  } alloc_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 kind = 1'b0;
  logic [SIZE_W-1:0]    request_size = '0;
  logic [ADDR_BITS-1:0] release_address = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [STAT_W-1:0]    status;
  logic [ADDR_BITS-1:0] block_address;
  logic [ORD_W-1:0]     block_order;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int         live_blocks[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_send = 1'b0;

  logic [1:0] tree[NODES] = '{default: ST_FREE};
  int         min_ord = 3;
  int         max_ord = 10;
  int         top_ord;
  int         depth_lim;
  int         hit_addr;
  int         hit_ord;

  always #5 clk = ~clk;

  buddy_block_allocator_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .kind(kind),
    .request_size(request_size), .release_address(release_address),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
    .block_address(block_address), .block_order(block_order)
  );

  function automatic void settle();
    int m;
    int lo;
    m = (max_ord > ADDR_BITS) ? ADDR_BITS : max_ord;
    lo = (min_ord > m) ? m : min_ord;
    if (m - lo > LEVELS) lo = m - LEVELS;
    top_ord = m;
    depth_lim = m - lo;
  endfunction

  function automatic bit carve(int idx, int depth, int start, longint need);
    int     ord;
    longint half;
    ord = top_ord - depth;
    half = (ord > 0) ? (longint'(1) << (ord - 1)) : 0;
    if (tree[idx] == ST_FREE) begin
      if (depth < depth_lim && need <= half) begin
        tree[idx] = ST_SPLIT;
        return carve(2 * idx + 1, depth + 1, start, need);
      end
      tree[idx] = ST_OCC;
      hit_addr = start;
      hit_ord = ord;
      return 1'b1;
    end
    if (tree[idx] == ST_SPLIT && depth < depth_lim && need <= half) begin
      if (carve(2 * idx + 1, depth + 1, start, need)) return 1'b1;
      return carve(2 * idx + 2, depth + 1, start + int'(half), need);
    end
    return 1'b0;
  endfunction

  function automatic bit merge_free(int idx, int depth, int start, int addr);
    int ord;
    int half;
    bit found;
    ord = top_ord - depth;
    half = (ord > 0) ? (1 << (ord - 1)) : 0;
    if (tree[idx] == ST_OCC) begin
      if (addr != start) return 1'b0;
      tree[idx] = ST_FREE;
      hit_addr = start;
      hit_ord = ord;
      return 1'b1;
    end
    if (tree[idx] != ST_SPLIT || depth >= depth_lim) return 1'b0;
    if (addr < start + half) found = merge_free(2 * idx + 1, depth + 1, start, addr);
    else found = merge_free(2 * idx + 2, depth + 1, start + half, addr);
    if (tree[2 * idx + 1] == ST_FREE && tree[2 * idx + 2] == ST_FREE) tree[idx] = ST_FREE;
    return found;
  endfunction

  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t e;
    int         pos;
    settle();
    hit_addr = 0;
    hit_ord = 0;
    pos = 0;
    if (r.kind == 1'b0) begin
      if (longint'(r.size) > (longint'(1) << top_ord)) e.st = RES_TOO_BIG;
      else if (carve(0, 0, 0, longint'(r.size))) e.st = RES_ALLOCATED;
      else e.st = RES_NO_SPACE;
    end else begin
      if (int'(r.addr) < (1 << top_ord) && merge_free(0, 0, 0, int'(r.addr)))
        e.st = RES_RELEASED;
      else e.st = RES_NOT_FOUND;
    end
    if (e.st == RES_ALLOCATED) live_blocks.push_back(hit_addr);
    if (e.st == RES_RELEASED) begin
      foreach (live_blocks[i]) if (live_blocks[i] == hit_addr) pos = i;
      live_blocks.delete(pos);
    end
    if (e.st != RES_ALLOCATED && e.st != RES_RELEASED) begin
      hit_addr = 0;
      hit_ord = 0;
    end
    e.addr = hit_addr[ADDR_BITS-1:0];
    e.ord = hit_ord[ORD_W-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    alloc_req_t cur;
    alloc_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        cur.kind = kind;
        cur.size = request_size;
        cur.addr = release_address;
        expected_rsps.push_back(predict_alloc(cur));
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          kind <= nxt.kind;
          request_size <= nxt.size;
          release_address <= nxt.addr;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          e = expected_rsps.pop_front();
          if (status !== e.st) report_mismatch("status", int'(status), int'(e.st));
          if (block_address !== e.addr)
            report_mismatch("block_address", int'(block_address), int'(e.addr));
          if (block_order !== e.ord)
            report_mismatch("block_order", int'(block_order), int'(e.ord));
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_ORDER || idx == REG_MAX_ORDER) begin
      if (idx == REG_MIN_ORDER) min_ord = val;
      else max_ord = val;
      foreach (tree[i]) tree[i] = ST_FREE;
      live_blocks.delete();
    end
  endtask

  task automatic send(bit k, int sz, int ad);
    alloc_req_t r;
    while (pending_reqs.size() > 0) @(posedge clk);
    r.kind = k;
    r.size = sz[SIZE_W-1:0];
    r.addr = ad[ADDR_BITS-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic random_items(int n);
    int r;
    int o;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        while (pending_reqs.size() > 0) @(posedge clk);
        hold_send = 1'b1;
        drain();
        hold_send = 1'b0;
      end
      settle();
      r = $urandom_range(99);
      if (r < 55) begin
        o = $urandom_range(0, top_ord);
        send(1'b0, 0, $urandom_range(0, 1023));
        pending_reqs[0].size = (o == 0) ? SIZE_W'($urandom_range(0, 1))
                                        : SIZE_W'($urandom_range((1 << (o - 1)), (1 << o)));
      end else if (r < 60) begin
        send(1'b0, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (r < 90 && live_blocks.size() > 0) begin
        send(1'b1, $urandom_range(0, 2047),
             live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else begin
        send(1'b1, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    int mins[8] = '{3, 0, 0, 10, 15, 2, 5, 1};
    int maxs[8] = '{10, 10, 0, 10, 15, 5, 2, 9};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(1'b0, 0, 0);
    send(1'b0, 1, 0);
    send(1'b0, 8, 0);
    send(1'b0, 9, 0);
    send(1'b0, 512, 0);
    send(1'b0, 1024, 0);
    send(1'b0, 1025, 0);
    send(1'b0, 2047, 0);
    send(1'b0, 256, 0);
    send(1'b1, 0, 0);
    send(1'b1, 0, 0);
    send(1'b1, 0, 1023);
    send(1'b1, 2047, 8);
    send(1'b1, 0, 16);
    send(1'b1, 0, 512);
    send(1'b0, 1024, 0);
    send(1'b0, 1, 0);
    send(1'b1, 0, 0);
    send(1'b0, 1024, 0);
    send(1'b1, 0, 0);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      write_reg(REG_MIN_ORDER, mins[p]);
      write_reg(REG_MAX_ORDER, maxs[p]);
      if (p == 3) write_reg(2, 7);
      if (p == 6) write_reg(3, 1);
      random_items(55);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS buddy_block_allocator_top");
    else $display("FAIL buddy_block_allocator_top");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL buddy_block_allocator_top");
    $finish;
  end

endmodule
